>>> rtl/core/sptq_pkg.sv
// Shared types and constants for the sparse table range query block.
`default_nettype none

package sptq_pkg;

    localparam int DATA_W    = 32;
    localparam int OP_W      = 3;
    localparam int FIRST_W   = 10;
    localparam int END_W     = 11;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    // Combining operators; the two unused codes behave as min.
    typedef enum logic [OP_W-1:0] {
        OP_MIN = 3'd0,
        OP_MAX = 3'd1,
        OP_ADD = 3'd2,
        OP_XOR = 3'd3,
        OP_AND = 3'd4,
        OP_OR  = 3'd5
    } op_t;

    localparam logic FUNC_UPDATE = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    // Register select bit of paddr: register i sits at byte address 4*i.
    localparam logic REG_OP_SELECT = 1'b0;
    localparam logic REG_IDENTITY  = 1'b1;

endpackage

`default_nettype wire

>>> rtl/core/sptq_alu.sv
// Shared combining unit: applies the selected associative operator to two words.
`default_nettype none

module sptq_alu (
    input  wire sptq_pkg::op_t                 op,
    input  wire logic [sptq_pkg::DATA_W-1:0]   a,
    input  wire logic [sptq_pkg::DATA_W-1:0]   b,
    output logic      [sptq_pkg::DATA_W-1:0]   y
);

    always_comb
    begin
        case (op)
            sptq_pkg::OP_MAX: y = (a > b) ? a : b;
            sptq_pkg::OP_ADD: y = a + b;
            sptq_pkg::OP_XOR: y = a ^ b;
            sptq_pkg::OP_AND: y = a & b;
            sptq_pkg::OP_OR:  y = a | b;
            default:          y = (a < b) ? a : b;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/sptq_mem.sv
// Span table memory: one write port and two registered read ports.
`default_nettype none

module sptq_mem #(
    parameter int DEPTH = 11264,
    parameter int AW    = 14,
    parameter int DW    = 33
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr_a,
    input  wire logic [AW-1:0] raddr_b,
    output logic      [DW-1:0] rdata_a,
    output logic      [DW-1:0] rdata_b
);

    logic [DW-1:0] ram_reg [0:DEPTH-1];
    logic [DW-1:0] rd_a_reg;
    logic [DW-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        rd_a_reg <= ram_reg[raddr_a];
        rd_b_reg <= ram_reg[raddr_b];
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule

`default_nettype wire

>>> rtl/core/sparse_table_range_query.sv
// Top level of the sparse table range query block: registers, sequencer and output stage.
//
//  Channel  Direction  Handshake            Payload
//  in       input      in_valid / in_stall  func, first_index, end_index, value
//  out      output     out_valid/out_stall  result
//  apb      config     psel/penable/pready  paddr, pwdata, pwrite, prdata
//
// After reset a clearing pass writes all LEVELS * 2**clog2(ARRAY_SIZE) table entries (11264
// by default) and marks each invalid; input transactions are stalled until it ends.
// An update writes the element at level 0, then for each higher level rebuilds, one span
// at a time through the single combining unit, every span that covers the element.
// A query steps down the levels from the top and combines the spans it reads one at a time.
// One transaction is processed at a time; a finished result waits in the output
// register while the next transaction is taken in.
`default_nettype none

module sparse_table_range_query #(
    parameter int ARRAY_SIZE = 1024,
    parameter int LEVELS     = 11
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic                             func,
    input  wire logic [sptq_pkg::FIRST_W-1:0]     first_index,
    input  wire logic [sptq_pkg::END_W-1:0]       end_index,
    input  wire logic [sptq_pkg::DATA_W-1:0]      value,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic      [sptq_pkg::DATA_W-1:0]      result,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [sptq_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [sptq_pkg::PDATA_W-1:0]     pwdata,
    output logic      [sptq_pkg::PDATA_W-1:0]     prdata,
    output logic                                  pready
);

    localparam int DW    = sptq_pkg::DATA_W;
    localparam int CW    = $clog2(ARRAY_SIZE);
    localparam int LW    = $clog2(LEVELS);
    localparam int DEPTH = LEVELS * (2 ** CW);
    localparam int MAW   = LW + CW;
    localparam int PW0   = (CW + 1 > sptq_pkg::END_W) ? CW + 1 : sptq_pkg::END_W;
    localparam int PW    = ((PW0 > LEVELS) ? PW0 : LEVELS) + 1;

    localparam logic [PW-1:0]  ASZ      = PW'(ARRAY_SIZE);
    localparam logic [LW-1:0]  TOP_LVL  = LW'(LEVELS - 1);
    localparam logic [MAW-1:0] LAST_ADR = MAW'(DEPTH - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_URD,
        S_UWR,
        S_QSCAN,
        S_QACC
    } state_t;

    state_t          state_reg,     state_next;
    logic [sptq_pkg::OP_W-1:0] op_reg, op_next;
    logic [DW-1:0]   ident_reg,     ident_next;
    logic            out_valid_reg, out_valid_next;
    logic [DW-1:0]   res_reg,       res_next;
    logic [DW-1:0]   acc_reg,       acc_next;
    logic [PW-1:0]   lo_reg,        lo_next;
    logic [PW-1:0]   hi_reg,        hi_next;
    logic [CW-1:0]   idx_reg,       idx_next;
    logic [CW-1:0]   col_reg,       col_next;
    logic [LW-1:0]   level_reg,     level_next;
    logic [MAW-1:0]  clr_reg,       clr_next;

    logic            mem_we;
    logic [MAW-1:0]  mem_waddr;
    logic [DW:0]     mem_wdata;
    logic [MAW-1:0]  mem_raddr_a;
    logic [MAW-1:0]  mem_raddr_b;
    logic [DW:0]     mem_rdata_a;
    logic [DW:0]     mem_rdata_b;

    logic [DW-1:0]   entry_a;
    logic [DW-1:0]   entry_b;
    logic [DW-1:0]   alu_a;
    logic [DW-1:0]   alu_b;
    logic [DW-1:0]   alu_y;

    logic            in_acc;
    logic            cfg_wr;
    logic [PW-1:0]   first_ext;
    logic [PW-1:0]   end_ext;
    logic [PW-1:0]   span_w;
    logic [PW-1:0]   half_w;
    logic [PW-1:0]   len_w;
    logic [PW-1:0]   idx_p1;
    logic [PW-1:0]   start_w;
    logic [PW-1:0]   start_b;
    logic [PW-1:0]   nc_w;
    logic [PW-1:0]   nc_b;
    logic            nc_ok;
    logic            span_ok;
    logic [LW-1:0]   lvl_below;

    sptq_mem #(
        .DEPTH (DEPTH),
        .AW    (MAW),
        .DW    (DW + 1)
    ) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (mem_rdata_a),
        .rdata_b (mem_rdata_b)
    );

    sptq_alu u_alu (
        .op (sptq_pkg::op_t'(op_reg)),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y)
    );

    function automatic logic [sptq_pkg::PDATA_W-1:0] PDATA_ZEXT(
        input logic [sptq_pkg::OP_W-1:0] v
    );
        PDATA_ZEXT = sptq_pkg::PDATA_W'(v);
    endfunction

    // An entry whose valid bit is clear reads as the current identity.
    assign entry_a = mem_rdata_a[DW] ? mem_rdata_a[DW-1:0] : ident_reg;
    assign entry_b = mem_rdata_b[DW] ? mem_rdata_b[DW-1:0] : ident_reg;

    assign alu_a = (state_reg == S_UWR) ? entry_a : acc_reg;
    assign alu_b = (state_reg == S_UWR) ? entry_b : entry_a;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_wr    = psel && penable && pwrite;
    assign first_ext = PW'(first_index);
    assign end_ext   = PW'(end_index);

    assign span_w    = PW'(1) << level_reg;
    assign half_w    = span_w >> 1;
    assign len_w     = hi_reg - lo_reg;
    assign lvl_below = level_reg - LW'(1);

    // First span of this level that covers the updated element.
    assign idx_p1  = PW'(idx_reg) + PW'(1);
    assign start_w = (idx_p1 >= span_w) ? (idx_p1 - span_w) : '0;
    assign start_b = start_w + half_w;
    assign span_ok = (span_w <= ASZ);

    assign nc_w  = PW'(col_reg) + PW'(1);
    assign nc_b  = nc_w + half_w;
    assign nc_ok = (nc_w <= PW'(idx_reg)) && ((nc_w + span_w) <= ASZ);

    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == sptq_pkg::REG_IDENTITY) ? ident_reg
                                                            : PDATA_ZEXT(op_reg);
    assign out_valid = out_valid_reg;
    assign result    = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        ident_next     = ident_reg;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        acc_next       = acc_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        idx_next       = idx_reg;
        col_next       = col_reg;
        level_next     = level_reg;
        clr_next       = clr_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_raddr_a    = '0;
        mem_raddr_b    = '0;

        if (cfg_wr)
        begin
            if (paddr[2] == sptq_pkg::REG_OP_SELECT)
            begin
                op_next = pwdata[sptq_pkg::OP_W-1:0];
            end
            else
            begin
                ident_next = pwdata[DW-1:0];
            end
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                if (clr_reg == LAST_ADR)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + MAW'(1);
                end
            end

            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (func == sptq_pkg::FUNC_QUERY)
                    begin
                        lo_next    = first_ext;
                        hi_next    = (end_ext > ASZ) ? ASZ : end_ext;
                        acc_next   = ident_reg;
                        level_next = TOP_LVL;
                        state_next = S_QSCAN;
                    end
                    else if (first_ext < ASZ)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = {LW'(0), first_ext[CW-1:0]};
                        mem_wdata  = {1'b1, value};
                        idx_next   = first_ext[CW-1:0];
                        level_next = LW'(1);
                        state_next = S_URD;
                    end
                end
            end

            S_URD:
            begin
                // A level whose span exceeds the array, and every level above it, is skipped.
                if (span_ok)
                begin
                    mem_raddr_a = {lvl_below, start_w[CW-1:0]};
                    mem_raddr_b = {lvl_below, start_b[CW-1:0]};
                    col_next    = start_w[CW-1:0];
                    state_next  = S_UWR;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_UWR:
            begin
                mem_we    = 1'b1;
                mem_waddr = {level_reg, col_reg};
                mem_wdata = {1'b1, alu_y};
                if (nc_ok)
                begin
                    mem_raddr_a = {lvl_below, nc_w[CW-1:0]};
                    mem_raddr_b = {lvl_below, nc_b[CW-1:0]};
                    col_next    = nc_w[CW-1:0];
                end
                else if (level_reg == TOP_LVL)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    level_next = level_reg + LW'(1);
                    state_next = S_URD;
                end
            end

            S_QSCAN:
            begin
                if (lo_reg >= hi_reg)
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        res_next       = acc_reg;
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else if (span_w > len_w)
                begin
                    // The remaining length only shrinks, so the level only steps down.
                    level_next = lvl_below;
                end
                else
                begin
                    mem_raddr_a = {level_reg, lo_reg[CW-1:0]};
                    lo_next     = lo_reg + span_w;
                    state_next  = S_QACC;
                end
            end

            S_QACC:
            begin
                acc_next   = alu_y;
                state_next = S_QSCAN;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            op_reg        <= '0;
            ident_reg     <= '0;
            out_valid_reg <= 1'b0;
            res_reg       <= '0;
            acc_reg       <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            idx_reg       <= '0;
            col_reg       <= '0;
            level_reg     <= '0;
            clr_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            ident_reg     <= ident_next;
            out_valid_reg <= out_valid_next;
            res_reg       <= res_next;
            acc_reg       <= acc_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            idx_reg       <= idx_next;
            col_reg       <= col_next;
            level_reg     <= level_next;
            clr_reg       <= clr_next;
        end
    end

    // A span read never moves the query position past the clamped end.
    a_lo_within_hi: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_QACC) |-> (lo_reg <= hi_reg))
        else $error("query position ran past the range end");

    a_hi_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_QSCAN || state_reg == S_QACC) |-> (hi_reg <= ASZ))
        else $error("query end not clamped to the array size");

    // Every rebuilt span must start at or before the updated element.
    a_col_covers_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UWR) |-> (col_reg <= idx_reg))
        else $error("rebuilt span does not cover the updated element");

    a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_QSCAN))
        else $error("result produced outside a query");

endmodule

`default_nettype wire

>>> tb/sparse_table_range_query_tb.sv
// Self-checking testbench for the sparse table range query block.
`timescale 1ns / 100ps

module sparse_table_range_query_tb;

    localparam int ARRAY_SIZE   = 1024;
    localparam int LEVELS       = 11;
    localparam int WINDOW       = 64;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 34;
    // Updates return nothing; the drain must cover the longest update rebuild.
    localparam int DRAIN_CYCLES = 2200;

    // Operator codes outside the named set; the block treats them as min.
    localparam logic [sptq_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [sptq_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

    class range_board;
        bit [sptq_pkg::OP_W-1:0]   op_code;
        bit [sptq_pkg::DATA_W-1:0] ident;
        bit [sptq_pkg::DATA_W-1:0] span_word [LEVELS][ARRAY_SIZE];
        bit                        span_ok   [LEVELS][ARRAY_SIZE];
        bit [sptq_pkg::DATA_W-1:0] pending_results [$];
        int updates_seen;
        int queries_seen;
        int results_checked;
        int mismatches;

        function void set_reg(logic sel, logic [sptq_pkg::PDATA_W-1:0] data);
            if (sel == sptq_pkg::REG_OP_SELECT)
                op_code = data[sptq_pkg::OP_W-1:0];
            else
                ident = data;
        endfunction

        function bit [sptq_pkg::DATA_W-1:0] merge(bit [sptq_pkg::DATA_W-1:0] a,
                                                  bit [sptq_pkg::DATA_W-1:0] b);
            case (op_code)
                sptq_pkg::OP_MAX: return (a > b) ? a : b;
                sptq_pkg::OP_ADD: return a + b;
                sptq_pkg::OP_XOR: return a ^ b;
                sptq_pkg::OP_AND: return a & b;
                sptq_pkg::OP_OR:  return a | b;
                default:          return (a < b) ? a : b;
            endcase
        endfunction

        // Entries never computed read as the current identity.
        function bit [sptq_pkg::DATA_W-1:0] entry_value(int lvl, int col);
            if (lvl >= LEVELS || col >= ARRAY_SIZE || !span_ok[lvl][col])
                return ident;
            return span_word[lvl][col];
        endfunction

        function void rebuild_spans(int idx, bit [sptq_pkg::DATA_W-1:0] val);
            int span;
            int col;
            if (idx >= ARRAY_SIZE)
                return;
            span_word[0][idx] = val;
            span_ok[0][idx]   = 1'b1;
            for (int lvl = 1; lvl < LEVELS; lvl++) begin
                span = 1 << lvl;
                col  = (idx + 1 >= span) ? idx + 1 - span : 0;
                for (; col <= idx; col++) begin
                    if (col + span > ARRAY_SIZE)
                        break;
                    span_word[lvl][col] = merge(entry_value(lvl - 1, col),
                                                entry_value(lvl - 1, col + span / 2));
                    span_ok[lvl][col] = 1'b1;
                end
            end
        endfunction

        function bit [sptq_pkg::DATA_W-1:0] range_value(int lo, int hi);
            bit [sptq_pkg::DATA_W-1:0] acc;
            int lvl;
            acc = ident;
            if (hi > ARRAY_SIZE)
                hi = ARRAY_SIZE;
            while (lo < hi) begin
                lvl = 0;
                while (lvl + 1 < LEVELS && (1 << (lvl + 1)) <= hi - lo)
                    lvl++;
                acc = merge(acc, entry_value(lvl, lo));
                lo += 1 << lvl;
            end
            return acc;
        endfunction

        function void note_transaction(logic f, logic [sptq_pkg::FIRST_W-1:0] fi,
                                       logic [sptq_pkg::END_W-1:0] ei,
                                       logic [sptq_pkg::DATA_W-1:0] v);
            if (f == sptq_pkg::FUNC_UPDATE) begin
                updates_seen++;
                rebuild_spans(int'(fi), v);
            end else begin
                queries_seen++;
                pending_results.push_back(range_value(int'(fi), int'(ei)));
            end
        endfunction

        function void check_result(logic [sptq_pkg::DATA_W-1:0] got);
            bit [sptq_pkg::DATA_W-1:0] want;
            if (pending_results.size() == 0) begin
                $error("result: no query outstanding, got %h", got);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            results_checked++;
            if (got !== want) begin
                $error("result mismatch: expected %h, got %h", want, got);
                mismatches++;
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n       = 1'b0;
    logic                            in_valid    = 1'b0;
    logic                            in_stall;
    logic                            func        = sptq_pkg::FUNC_UPDATE;
    logic [sptq_pkg::FIRST_W-1:0]    first_index = '0;
    logic [sptq_pkg::END_W-1:0]      end_index   = '0;
    logic [sptq_pkg::DATA_W-1:0]     value       = '0;
    logic                            out_valid;
    logic                            out_stall   = 1'b0;
    logic [sptq_pkg::DATA_W-1:0]     result;
    logic                            psel        = 1'b0;
    logic                            penable     = 1'b0;
    logic                            pwrite      = 1'b0;
    logic [sptq_pkg::PADDR_W-1:0]    paddr       = '0;
    logic [sptq_pkg::PDATA_W-1:0]    pwdata      = '0;
    logic [sptq_pkg::PDATA_W-1:0]    prdata;
    logic                            pready;

    // When set, neither side inserts gaps or stalls.
    bit steady = 1'b0;

    range_board sb = new();

    sparse_table_range_query #(
        .ARRAY_SIZE (ARRAY_SIZE),
        .LEVELS     (LEVELS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .first_index (first_index),
        .end_index   (end_index),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result      (result),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_stall <= !steady && ($urandom_range(0, 99) < 10);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(result);
            if (in_valid && !in_stall)
                sb.note_transaction(func, first_index, end_index, value);
        end
    end

    task automatic write_reg(input logic sel, input logic [sptq_pkg::PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= sptq_pkg::PADDR_W'({sel, 2'b00});
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(sel, data);
        @(posedge clk);
    endtask

    task automatic send_item(input logic f, input int fi, input int ei,
                             input logic [sptq_pkg::DATA_W-1:0] v);
        if (!steady)
            while ($urandom_range(0, 99) < 10)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid    <= 1'b1;
        func        <= f;
        first_index <= fi[sptq_pkg::FIRST_W-1:0];
        end_index   <= ei[sptq_pkg::END_W-1:0];
        value       <= v;
        do @(posedge clk); while (in_stall);
    endtask

    function automatic logic [sptq_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0:       return $urandom | $urandom;
            1:       return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    // Updates and queries mostly land in one window so that queries see built spans.
    task automatic run_phase(input int n, input int base);
        int lo;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < 45)
            begin
                if ($urandom_range(0, 9) == 0)
                    lo = $urandom_range(0, ARRAY_SIZE - 1);
                else
                    lo = base + $urandom_range(0, WINDOW - 1);
                send_item(sptq_pkg::FUNC_UPDATE, lo, $urandom_range(0, 2047), pick_value());
            end
            else if ($urandom_range(0, 4) == 0)
                send_item(sptq_pkg::FUNC_QUERY, $urandom_range(0, 1023),
                          $urandom_range(0, 2047), $urandom);
            else
            begin
                lo = base + $urandom_range(0, WINDOW - 1);
                send_item(sptq_pkg::FUNC_QUERY, lo, lo + $urandom_range(0, WINDOW),
                          $urandom);
            end
        end
        in_valid <= 1'b0;
    endtask

    task automatic settle();
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    logic [sptq_pkg::OP_W-1:0]   phase_op    [PHASES] = '{sptq_pkg::OP_MAX, sptq_pkg::OP_ADD,
                                                          sptq_pkg::OP_XOR, sptq_pkg::OP_AND,
                                                          sptq_pkg::OP_OR, OP_SPARE_6,
                                                          OP_SPARE_7, sptq_pkg::OP_MIN};
    logic [sptq_pkg::DATA_W-1:0] phase_ident [PHASES] = '{32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF,
                                                          32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0};

    initial
    begin
        int base;
        logic [sptq_pkg::DATA_W-1:0] ident;
        rst_n <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(sptq_pkg::REG_OP_SELECT, sptq_pkg::PDATA_W'(sptq_pkg::OP_MIN));
        write_reg(sptq_pkg::REG_IDENTITY, 32'hFFFF_FFFF);

        // Directed part: empty table, both array ends, clamped and empty ranges.
        send_item(sptq_pkg::FUNC_QUERY,  0,    1024, 32'h0);
        send_item(sptq_pkg::FUNC_UPDATE, 0,    0,    32'h1234_5678);
        send_item(sptq_pkg::FUNC_UPDATE, 1023, 2047, 32'hFFFF_FFFF);
        send_item(sptq_pkg::FUNC_UPDATE, 1022, 0,    32'h0000_0000);
        send_item(sptq_pkg::FUNC_UPDATE, 1,    5,    32'h8000_0001);
        send_item(sptq_pkg::FUNC_UPDATE, 512,  0,    32'h0000_00FF);
        send_item(sptq_pkg::FUNC_QUERY,  0,    2,    32'hFFFF_FFFF);
        send_item(sptq_pkg::FUNC_QUERY,  0,    1024, 32'h0);
        send_item(sptq_pkg::FUNC_QUERY,  1022, 1024, 32'h0);
        send_item(sptq_pkg::FUNC_QUERY,  1023, 2047, 32'h0);
        send_item(sptq_pkg::FUNC_QUERY,  0,    0,    32'h0);
        send_item(sptq_pkg::FUNC_QUERY,  1023, 0,    32'h0);
        send_item(sptq_pkg::FUNC_QUERY,  5,    5,    32'h0);
        send_item(sptq_pkg::FUNC_QUERY,  0,    1,    32'h0);
        send_item(sptq_pkg::FUNC_QUERY,  1,    1023, 32'h0);
        send_item(sptq_pkg::FUNC_QUERY,  511,  1000, 32'h0);
        send_item(sptq_pkg::FUNC_QUERY,  1020, 1025, 32'h0);
        send_item(sptq_pkg::FUNC_UPDATE, 1023, 0,    32'h0000_0000);
        send_item(sptq_pkg::FUNC_QUERY,  1000, 1024, 32'h0);
        send_item(sptq_pkg::FUNC_UPDATE, 2,    0,    32'h7FFF_FFFF);
        send_item(sptq_pkg::FUNC_QUERY,  0,    3,    32'h0);
        in_valid <= 1'b0;
        settle();

        // Each phase changes the operator; spans built earlier keep their old values.
        for (int p = 0; p < PHASES; p++)
        begin
            ident = (p >= 6) ? $urandom : phase_ident[p];
            write_reg(sptq_pkg::REG_OP_SELECT, sptq_pkg::PDATA_W'(phase_op[p]));
            write_reg(sptq_pkg::REG_IDENTITY, ident);
            steady = (p == 2);
            case (p % 3)
                0:       base = 0;
                1:       base = ARRAY_SIZE - WINDOW;
                default: base = $urandom_range(WINDOW, ARRAY_SIZE - 2 * WINDOW);
            endcase
            run_phase(PHASE_ITEMS, base);
            settle();
        end

        $display("Ran %0d updates and %0d range queries across %0d operator settings.",
                 sb.updates_seen, sb.queries_seen, PHASES + 1);
        $display("Checked %0d results, %0d mismatches.", sb.results_checked, sb.mismatches);
        if (sb.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #60_000_000;
        $display("Timed out with %0d query results outstanding.",
                 sb.pending_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
